### rtl/ppg_pkg.sv
// ----------------------------------------------------------------------------
// Plasma pixel generator package
// Widths, window origin and the sine table shared by the plasma pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ppg_pkg;

    localparam int COORD_W = 6;   // col / row width, 64 wide window
    localparam int ANGLE_W = 9;   // table index, 512 values; the sine wave repeats every 256
    localparam int TRIG_W  = 10;  // signed table value, -256..256
    localparam int AMP_W   = 11;  // signed amplitude, -512..512
    localparam int PROD_W  = TRIG_W + AMP_W;
    localparam int PIXEL_W = 16;

    localparam logic [6:0] ORIGIN = 7'd30;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 9'd64;

    typedef logic [ANGLE_W-1:0]        angle_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [AMP_W-1:0]   amp_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // trunc(256*sin(m*pi/128)) for m = 0..64
    localparam logic [8:0] QUARTER_WAVE [0:64] = '{
        9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,  9'd49,
        9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,  9'd97,  9'd103,
        9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136, 9'd142, 9'd147, 9'd152,
        9'd157, 9'd162, 9'd167, 9'd171, 9'd176, 9'd181, 9'd185, 9'd189, 9'd193,
        9'd197, 9'd201, 9'd205, 9'd209, 9'd212, 9'd216, 9'd219, 9'd222, 9'd225,
        9'd228, 9'd231, 9'd234, 9'd236, 9'd238, 9'd241, 9'd243, 9'd244, 9'd246,
        9'd248, 9'd249, 9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255,
        9'd255, 9'd256
    };

    // Full sine wave rebuilt from the quarter wave; period is 256 entries.
    function automatic trig_t sin_lookup(input angle_t idx);
        logic [1:0]        quad;
        logic [5:0]        m;
        logic [6:0]        k;
        logic [TRIG_W-1:0] mag;
        quad = idx[7:6];
        m    = idx[5:0];
        if (quad[0])
            k = 7'd64 - {1'b0, m};
        else
            k = {1'b0, m};
        mag = {1'b0, QUARTER_WAVE[k]};
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic trig_t cos_lookup(input angle_t idx);
        return sin_lookup(idx + QUARTER_TURN);
    endfunction

    // Twice a table value, as an amplitude
    function automatic amp_t double_amp(input trig_t v);
        return $signed({v, 1'b0});
    endfunction

endpackage

`default_nettype wire

### rtl/plasma_pixel_generator.sv
// ----------------------------------------------------------------------------
// Plasma pixel generator
// Four-stage pipeline producing one RGB565 plasma pixel per input beat.
// ----------------------------------------------------------------------------
// Takes one (col, row, advance_frame) beat per clock while in_stall is low
// and returns one RGB565 pixel per beat, in order. Each beat moves through
// the stage 1, 2 and 3 registers into the output register. The frame state
// (angles and amplitudes) steps at the accept edge of a beat with
// advance_frame set, and each beat carries a snapshot of that state down the
// pipe, so frames may change between neighboring beats. Stages: state
// snapshot, table lookup, 10x11 signed multiply, divide/sum/fold into the
// pixel register. The single multiply stage sets the clock period;
// throughput is one pixel per cycle while the output side keeps stall low,
// and a stall reaches the input only once every stage is full.
`default_nettype none

module plasma_pixel_generator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [ppg_pkg::COORD_W-1:0] col,
    input  wire logic [ppg_pkg::COORD_W-1:0] row,
    input  wire logic                        advance_frame,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [ppg_pkg::PIXEL_W-1:0]      pixel
);

    // frame state
    ppg_pkg::angle_t x_angle_reg, x_angle_next;
    ppg_pkg::angle_t y_angle_reg, y_angle_next;
    ppg_pkg::amp_t   x_amp_reg, x_amp_next;
    ppg_pkg::amp_t   y_amp_reg, y_amp_next;

    // stage 1: coordinates and state snapshot
    logic            s1_valid_reg;
    logic [6:0]      s1_x_reg, s1_y_reg;
    ppg_pkg::angle_t s1_xang_reg, s1_yang_reg;
    ppg_pkg::amp_t   s1_xamp_reg, s1_yamp_reg;

    // stage 2: table values
    logic            s2_valid_reg;
    logic [7:0]      s2_xy_reg;
    ppg_pkg::trig_t  s2_sin_reg, s2_cos_reg;
    ppg_pkg::amp_t   s2_xamp_reg, s2_yamp_reg;

    // stage 3: products
    logic            s3_valid_reg;
    logic [7:0]      s3_xy_reg;
    ppg_pkg::prod_t  s3_pprod_reg, s3_qprod_reg;

    // output register
    logic                         out_valid_reg;
    logic [ppg_pkg::PIXEL_W-1:0]  pixel_reg, pixel_next;

    logic in_accept;
    logic out_ready, s3_ready, s2_ready, s1_ready;

    ppg_pkg::angle_t sin_idx, cos_idx;
    logic [8:0]      y_times3;
    ppg_pkg::prod_t  p_adj, q_adj;
    logic [7:0]      r_sum;
    logic [6:0]      r_fold;

    // ---------------------------------------------------------------- flow
    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;

    // ---------------------------------------------------------- frame step
    always_comb
    begin
        x_angle_next = x_angle_reg;
        y_angle_next = y_angle_reg;
        x_amp_next   = x_amp_reg;
        y_amp_next   = y_amp_reg;
        if (in_accept && advance_frame)
        begin
            x_angle_next = x_angle_reg + 9'd1;
            y_angle_next = y_angle_reg - 9'd1;
            x_amp_next   = ppg_pkg::double_amp(ppg_pkg::cos_lookup(y_angle_next));
            y_amp_next   = ppg_pkg::double_amp(ppg_pkg::sin_lookup(x_angle_next));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_angle_reg <= '0;
            y_angle_reg <= '0;
            x_amp_reg   <= 11'sd256;
            y_amp_reg   <= 11'sd256;
        end
        else
        begin
            x_angle_reg <= x_angle_next;
            y_angle_reg <= y_angle_next;
            x_amp_reg   <= x_amp_next;
            y_amp_reg   <= y_amp_next;
        end
    end

    // ------------------------------------------------------- stage compute
    assign y_times3 = {2'b00, s1_y_reg} + {1'b0, s1_y_reg, 1'b0};
    assign sin_idx  = s1_xang_reg + y_times3;
    assign cos_idx  = s1_yang_reg + {s1_x_reg, 2'b00};

    // Truncate toward zero: bias negative products before the shift
    assign p_adj = s3_pprod_reg + (s3_pprod_reg[ppg_pkg::PROD_W-1] ? 21'sd255 : 21'sd0);
    assign q_adj = s3_qprod_reg + (s3_qprod_reg[ppg_pkg::PROD_W-1] ? 21'sd255 : 21'sd0);

    always_comb
    begin
        r_sum      = s3_xy_reg + p_adj[15:8] + q_adj[15:8];
        // fold the upper half back down: 255 - r
        r_fold     = r_sum[7] ? ~r_sum[6:0] : r_sum[6:0];
        pixel_next = {1'b0, r_fold[6:3], 1'b0, r_fold[6:2], 1'b0, r_fold[6:3]};
    end

    // --------------------------------------------------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (out_ready)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------ payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg    <= {1'b0, col} + ppg_pkg::ORIGIN;
            s1_y_reg    <= {1'b0, row} + ppg_pkg::ORIGIN;
            s1_xang_reg <= x_angle_next;
            s1_yang_reg <= y_angle_next;
            s1_xamp_reg <= x_amp_next;
            s1_yamp_reg <= y_amp_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_xy_reg   <= {1'b0, s1_x_reg} + {1'b0, s1_y_reg};
            s2_sin_reg  <= ppg_pkg::sin_lookup(sin_idx);
            s2_cos_reg  <= ppg_pkg::cos_lookup(cos_idx);
            s2_xamp_reg <= s1_xamp_reg;
            s2_yamp_reg <= s1_yamp_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_xy_reg    <= s2_xy_reg;
            s3_pprod_reg <= s2_sin_reg * s2_xamp_reg;
            s3_qprod_reg <= s2_cos_reg * s2_yamp_reg;
        end
        if (out_ready && s3_valid_reg)
            pixel_reg <= pixel_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;

`ifndef SYNTHESIS
    // advance steps the angles at the accept edge
    a_x_angle_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && advance_frame |=> x_angle_reg == $past(x_angle_reg) + 9'd1)
        else $error("x angle did not advance");

    a_y_angle_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && advance_frame |=> y_angle_reg == $past(y_angle_reg) - 9'd1)
        else $error("y angle did not step back");

    // input may only stall when every stage is full behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall && s3_valid_reg
                     && s2_valid_reg && s1_valid_reg)
        else $error("input stalled with room in the pipe");

    // frame amplitudes hold without an advancing beat
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && advance_frame) |=> $stable(x_amp_reg) && $stable(y_amp_reg))
        else $error("amplitudes changed without a frame advance");
`endif

endmodule

`default_nettype wire

### tb/plasma_pixel_generator_tb.sv
// ----------------------------------------------------------------------------
// Plasma pixel generator testbench
// Sends (col, row, advance_frame) beats, predicts each RGB565 pixel from its
// own copy of the frame angles and amplitudes, and checks every returned pixel
// in order. The input idles and the output stalls at random in several phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module plasma_pixel_generator_tb;

    localparam int WINDOW_ORIGIN = 30;
    localparam int ANGLE_MASK    = 511;

    // trunc(256*sin(m*pi/128)) for m = 0..64
    localparam int QUARTER_SINE [0:64] = '{
          0,   6,  12,  18,  25,  31,  37,  43,  49,  56,  62,  68,  74,
         80,  86,  92,  97, 103, 109, 115, 120, 126, 131, 136, 142, 147,
        152, 157, 162, 167, 171, 176, 181, 185, 189, 193, 197, 201, 205,
        209, 212, 216, 219, 222, 225, 228, 231, 234, 236, 238, 241, 243,
        244, 246, 248, 249, 251, 252, 253, 254, 254, 255, 255, 255, 256
    };

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          in_valid      = 1'b0;
    logic                          in_stall;
    logic [ppg_pkg::COORD_W-1:0]   col           = '0;
    logic [ppg_pkg::COORD_W-1:0]   row           = '0;
    logic                          advance_frame = 1'b0;
    logic                          out_valid;
    logic                          out_stall     = 1'b0;
    logic [ppg_pkg::PIXEL_W-1:0]   pixel;

    // Frame state as the block should hold it
    logic [ppg_pkg::ANGLE_W-1:0]   x_angle = '0;
    logic [ppg_pkg::ANGLE_W-1:0]   y_angle = '0;
    int                            x_amp   = 256;
    int                            y_amp   = 256;

    logic [ppg_pkg::PIXEL_W-1:0]   expected_pixels [$];
    logic [ppg_pkg::PIXEL_W-1:0]   want_pixel;
    int                            error_count = 0;
    int                            idle_pct    = 0;
    int                            stall_pct   = 0;

    plasma_pixel_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .col           (col),
        .row           (row),
        .advance_frame (advance_frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel         (pixel)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int sine_value(input int idx);
        int t;
        int m;
        int mag;
        t = idx & 255;
        m = t & 63;
        mag = (t & 64) ? QUARTER_SINE[64 - m] : QUARTER_SINE[m];
        return (t & 128) ? -mag : mag;
    endfunction

    function automatic int cosine_value(input int idx);
        return sine_value(idx + 64);
    endfunction

    // Pixel from the current frame state; divisions truncate toward zero
    function automatic logic [ppg_pkg::PIXEL_W-1:0] plasma_pixel(input int c, input int r);
        int         x;
        int         y;
        int         p;
        int         q;
        logic [7:0] fold;
        x = c + WINDOW_ORIGIN;
        y = r + WINDOW_ORIGIN;
        p = x + (sine_value((int'(x_angle) + 3 * y) & ANGLE_MASK) * x_amp) / 256;
        q = y + (cosine_value((int'(y_angle) + 4 * x) & ANGLE_MASK) * y_amp) / 256;
        fold = 8'(p + q);
        if (fold >= 8'd128)
            fold = 8'd255 - fold;
        return {fold[7:3], fold[7:2], fold[7:3]};
    endfunction

    task automatic step_frame();
        x_angle = (x_angle + 9'd1) & 9'(ANGLE_MASK);
        y_angle = (y_angle + 9'(ANGLE_MASK)) & 9'(ANGLE_MASK);
        x_amp   = 2 * cosine_value(int'(y_angle));
        y_amp   = 2 * sine_value(int'(x_angle));
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Send one beat, idling first at the current rate, and predict its pixel
    task automatic send_beat(input logic [ppg_pkg::COORD_W-1:0] c,
                             input logic [ppg_pkg::COORD_W-1:0] r,
                             input logic adv);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid      <= 1'b0;
            col           <= ppg_pkg::COORD_W'($urandom);
            row           <= ppg_pkg::COORD_W'($urandom);
            advance_frame <= 1'($urandom);
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        col           <= c;
        row           <= r;
        advance_frame <= adv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (adv)
            step_frame();
        expected_pixels.push_back(plasma_pixel(int'(c), int'(r)));
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("pixel %h with none expected", pixel));
            else
            begin
                want_pixel = expected_pixels.pop_front();
                if (pixel !== want_pixel)
                    report_mismatch($sformatf("pixel %h, expected %h", pixel, want_pixel));
            end
        end
    end

    // Reset frame state, extremes of the window and one point inside it
    task automatic test_window_corners();
        send_beat(6'd0, 6'd0, 1'b0);
        send_beat(6'd63, 6'd63, 1'b0);
        send_beat(6'd0, 6'd63, 1'b0);
        send_beat(6'd63, 6'd0, 1'b0);
        send_beat(6'd42, 6'd21, 1'b0);
    endtask

    // Frame steps back to back and between plain pixels; y angle wraps at once
    task automatic test_frame_advance();
        send_beat(6'd0, 6'd0, 1'b1);
        send_beat(6'd63, 6'd63, 1'b1);
        send_beat(6'd31, 6'd32, 1'b1);
        send_beat(6'd63, 6'd0, 1'b0);
        send_beat(6'd0, 6'd63, 1'b0);
        send_beat(6'd21, 6'd42, 1'b1);
        send_beat(6'd42, 6'd21, 1'b0);
        send_beat(6'd1, 6'd62, 1'b1);
        send_beat(6'd62, 6'd1, 1'b1);
        send_beat(6'd32, 6'd31, 1'b0);
    endtask

    // Short frames: an advancing beat, then a few plain pixels, now and then
    // a stray advance inside the frame
    task automatic test_random_frames(input int idle, input int stall, input int n_beats);
        int sent;
        int extra;
        sent      = 0;
        idle_pct  = idle;
        stall_pct = stall;
        while (sent < n_beats)
        begin
            send_beat(ppg_pkg::COORD_W'($urandom), ppg_pkg::COORD_W'($urandom), 1'b1);
            sent++;
            extra = $urandom_range(3);
            repeat (extra)
            begin
                send_beat(ppg_pkg::COORD_W'($urandom), ppg_pkg::COORD_W'($urandom),
                          ($urandom_range(9) == 0));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_window_corners();
        test_frame_advance();
        test_random_frames(0, 0, 425);
        test_random_frames(68, 0, 425);
        test_random_frames(0, 68, 425);
        test_random_frames(21, 21, 425);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/ppg_pkg.sv
rtl/plasma_pixel_generator.sv
tb/plasma_pixel_generator_tb.sv
